FILE: hw/rtl/key_sensor_to_note_events_unit_assert.svh
// Assertion macros used by the key sensor top level.
`ifndef KEY_SENSOR_TO_NOTE_EVENTS_UNIT_ASSERT_SVH
`define KEY_SENSOR_TO_NOTE_EVENTS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KSNE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define KSNE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define KSNE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KSNE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/ksne_pkg.sv
// Types and constants of the key sensor to note event unit.
`default_nettype none
package ksne_pkg;

	typedef struct packed {
		logic [1:0] req_type;
		logic [4:0] key_index;
		logic [9:0] reading;
	} key_req_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [4:0] key_out;
		logic [6:0] note;
		logic [6:0] amount;
		logic [9:0] cal_min;
		logic [9:0] cal_max;
	} note_evt_t;

	localparam logic [1:0] REQ_READING   = 2'd0;
	localparam logic [1:0] REQ_CAL_BEGIN = 2'd1;
	localparam logic [1:0] REQ_CAL_END   = 2'd2;

	localparam logic [2:0] EV_NONE          = 3'd0;
	localparam logic [2:0] EV_NOTE_ON       = 3'd1;
	localparam logic [2:0] EV_NOTE_OFF      = 3'd2;
	localparam logic [2:0] EV_POLY_PRESSURE = 3'd3;
	localparam logic [2:0] EV_CAL_UPDATE    = 3'd4;

	localparam logic [2:0] REG_PLAY_MODE        = 3'd0;
	localparam logic [2:0] REG_NOTE_THRESHOLD   = 3'd1;
	localparam logic [2:0] REG_PRESSURE_FLOOR   = 3'd2;
	localparam logic [2:0] REG_PRESSURE_CEILING = 3'd3;
	localparam logic [2:0] REG_NOTE_NUMBER      = 3'd4;
	localparam logic [2:0] REG_ACTIVE_KEYS      = 3'd5;

	localparam logic        RST_PLAY_MODE   = 1'b0;
	localparam logic [9:0]  RST_THRESHOLD   = 10'd350;
	localparam logic [9:0]  RST_FLOOR       = 10'd300;
	localparam logic [9:0]  RST_CEILING     = 10'd480;
	localparam logic [6:0]  RST_NOTE_NUMBER = 7'd60;
	localparam logic [5:0]  RST_ACTIVE_KEYS = 6'd3;

	localparam logic [9:0]  READING_MAX = 10'd1023;
	localparam logic [6:0]  MIDI_MAX    = 7'd127;

	// pressure divider: 18-bit dividend 2n+d, 11-bit divisor 2d
	localparam int NUM_W      = 18;
	localparam int DEN_W      = 11;
	localparam int DIV_STEPS  = NUM_W;

endpackage
`default_nettype wire

FILE: hw/rtl/key_sensor_to_note_events_unit.sv
// Top level of the key sensor to note event unit.
`default_nettype none
`include "key_sensor_to_note_events_unit_assert.svh"
// Turns per-key sensor readings into note events, one result transaction for every request
// transaction (kind none where nothing happens). Requests, calibration reads and velocity-mode
// readings go from acceptance through the load and finish states back to ready; a pressure-mode
// reading of an active key also passes the prepare, divide and decide states, where one 18-step
// restoring divider computes the pressure of the new reading and then of the last one (a pressure
// known to be zero skips its division). A finished result waits in the output register while the
// next request is accepted. Per-key tables are memories with one valid bit per entry, so reset
// clears them all and begin-calibration clears the min and max tables at once without a sweep.
module key_sensor_to_note_events_unit #(
	parameter int KEY_COUNT = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_ready,
	input  ksne_pkg::key_req_t  req_data,
	output logic                evt_valid,
	input  logic                evt_ready,
	output ksne_pkg::note_evt_t evt_data
);
	import ksne_pkg::*;

	localparam int AW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOAD   = 6'b000010,
		ST_PREP   = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_DECIDE = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;

	logic                 play_mode_q;
	logic [9:0]           threshold_q;
	logic [9:0]           floor_q;
	logic [9:0]           ceiling_q;
	logic [6:0]           note_num_q;
	logic [5:0]           active_keys_q;

	logic                 calibrating_q;
	logic [KEY_COUNT-1:0] last_vld_q;
	logic [KEY_COUNT-1:0] cal_vld_q;

	logic [9:0]           last_mem [KEY_COUNT];
	logic [9:0]           min_mem  [KEY_COUNT];
	logic [9:0]           max_mem  [KEY_COUNT];
	logic [9:0]           rd_last_q;
	logic [9:0]           rd_min_q;
	logic [9:0]           rd_max_q;

	key_req_t             req_q;
	logic [9:0]           last_q;
	logic                 sel_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [6:0]           p_r_q;
	logic [6:0]           p_l_q;
	logic [2:0]           kind_q;
	logic [6:0]           amount_q;
	logic [9:0]           cmin_q;
	logic [9:0]           cmax_q;
	logic                 evt_valid_q;
	note_evt_t            evt_q;

	logic                 req_acc;
	logic                 cfg_wr;
	logic [AW-1:0]        in_addr;
	logic [AW-1:0]        key_addr;
	logic                 key_ok;
	logic                 key_active;
	logic                 evt_free;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign in_addr   = AW'(req_data.key_index);
	assign key_addr  = AW'(req_q.key_index);
	assign key_ok    = (9'(req_q.key_index) < 9'(KEY_COUNT));
	assign key_active = (6'(req_q.key_index) < active_keys_q);
	assign evt_free  = !evt_valid_q || evt_ready;
	assign evt_valid = evt_valid_q;
	assign evt_data  = evt_q;

	always_comb begin
		unique case (paddr[4:2])
			REG_PLAY_MODE:        prdata = 32'(play_mode_q);
			REG_NOTE_THRESHOLD:   prdata = 32'(threshold_q);
			REG_PRESSURE_FLOOR:   prdata = 32'(floor_q);
			REG_PRESSURE_CEILING: prdata = 32'(ceiling_q);
			REG_NOTE_NUMBER:      prdata = 32'(note_num_q);
			REG_ACTIVE_KEYS:      prdata = 32'(active_keys_q);
			default:              prdata = 32'd0;
		endcase
	end

	// table entries that were never written read as their reset values
	logic [9:0] last_val;
	logic [9:0] cmin_old;
	logic [9:0] cmax_old;
	logic [9:0] new_min;
	logic [9:0] new_max;

	assign last_val = last_vld_q[key_addr] ? rd_last_q : 10'd0;
	assign cmin_old = cal_vld_q[key_addr] ? rd_min_q : READING_MAX;
	assign cmax_old = cal_vld_q[key_addr] ? rd_max_q : 10'd0;
	assign new_min  = (req_q.reading < cmin_old) ? req_q.reading : cmin_old;
	assign new_max  = (req_q.reading > cmax_old) ? req_q.reading : cmax_old;

	logic [9:0]  fall;
	logic [10:0] vel2;
	logic [6:0]  vel;
	logic        vel_on;
	logic        vel_off;

	assign fall    = last_val - req_q.reading;
	assign vel2    = {fall, 1'b0};
	assign vel     = (|vel2[10:7]) ? MIDI_MAX : vel2[6:0];
	assign vel_on  = (req_q.reading <= threshold_q) && (threshold_q < last_val);
	assign vel_off = (last_val <= threshold_q) && (threshold_q < req_q.reading);

	// decision taken once the tables have been read
	logic       last_we;
	logic       cal_we;
	logic       cal_begin;
	logic       cal_end;
	logic       to_prep;
	logic [2:0] load_kind;
	logic [6:0] load_amount;
	logic [9:0] load_cmin;
	logic [9:0] load_cmax;

	always_comb begin
		last_we     = 1'b0;
		cal_we      = 1'b0;
		cal_begin   = 1'b0;
		cal_end     = 1'b0;
		to_prep     = 1'b0;
		load_kind   = EV_NONE;
		load_amount = 7'd0;
		load_cmin   = 10'd0;
		load_cmax   = 10'd0;
		if (state_q == ST_LOAD) begin
			case (req_q.req_type)
				REQ_CAL_BEGIN: cal_begin = !calibrating_q;
				REQ_CAL_END:   cal_end = 1'b1;
				REQ_READING: begin
					if (key_ok && calibrating_q) begin
						cal_we    = 1'b1;
						load_kind = EV_CAL_UPDATE;
						load_cmin = new_min;
						load_cmax = new_max;
					end else if (key_ok) begin
						last_we = 1'b1;
						if (key_active && play_mode_q) begin
							to_prep = 1'b1;
						end else if (key_active && vel_on) begin
							load_kind   = EV_NOTE_ON;
							load_amount = vel;
						end else if (key_active && vel_off) begin
							load_kind = EV_NOTE_OFF;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// pressure operand setup: dividend 2*127*(ceiling-x)+d, divisor 2*d
	logic [9:0]       p_x;
	logic             p_zero;
	logic [9:0]       p_diff;
	logic [9:0]       p_range;
	logic [16:0]      p_n;
	logic [NUM_W-1:0] p_num;

	assign p_x     = sel_q ? last_q : req_q.reading;
	assign p_zero  = (ceiling_q <= floor_q) || (p_x >= ceiling_q);
	assign p_diff  = ceiling_q - p_x;
	assign p_range = ceiling_q - floor_q;
	assign p_n     = {p_diff, 7'd0} - 17'(p_diff);
	assign p_num   = {p_n, 1'b0} + NUM_W'(p_range);

	// one restoring step of the shared divider
	logic [DEN_W:0]   div_shift;
	logic [DEN_W:0]   div_trial;
	logic             div_ge;
	logic [DEN_W-1:0] rem_next;
	logic [NUM_W-1:0] num_next;
	logic [6:0]       q_clamp;
	logic             div_last;

	assign div_shift = {rem_q, num_q[NUM_W-1]};
	assign div_trial = div_shift - {1'b0, den_q};
	assign div_ge    = !div_trial[DEN_W];
	assign rem_next  = div_ge ? div_trial[DEN_W-1:0] : div_shift[DEN_W-1:0];
	assign num_next  = {num_q[NUM_W-2:0], div_ge};
	assign q_clamp   = (|num_next[NUM_W-1:7]) ? MIDI_MAX : num_next[6:0];
	assign div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));

	logic [2:0] dec_kind;
	logic [6:0] dec_amount;

	always_comb begin
		dec_kind   = EV_NONE;
		dec_amount = 7'd0;
		if (p_r_q != 7'd0) begin
			dec_kind   = (p_l_q == 7'd0) ? EV_NOTE_ON : EV_POLY_PRESSURE;
			dec_amount = p_r_q;
		end else if (p_l_q != 7'd0) begin
			dec_kind = EV_NOTE_OFF;
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		if (req_acc) begin
			rd_last_q <= last_mem[in_addr];
			rd_min_q  <= min_mem[in_addr];
			rd_max_q  <= max_mem[in_addr];
		end
		if (last_we) last_mem[key_addr] <= req_q.reading;
		if (cal_we) begin
			min_mem[key_addr] <= new_min;
			max_mem[key_addr] <= new_max;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			play_mode_q   <= RST_PLAY_MODE;
			threshold_q   <= RST_THRESHOLD;
			floor_q       <= RST_FLOOR;
			ceiling_q     <= RST_CEILING;
			note_num_q    <= RST_NOTE_NUMBER;
			active_keys_q <= RST_ACTIVE_KEYS;
			calibrating_q <= 1'b0;
			last_vld_q    <= '0;
			cal_vld_q     <= '0;
			sel_q         <= 1'b0;
			cnt_q         <= '0;
			evt_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[4:2])
					REG_PLAY_MODE:        play_mode_q   <= pwdata[0];
					REG_NOTE_THRESHOLD:   threshold_q   <= pwdata[9:0];
					REG_PRESSURE_FLOOR:   floor_q       <= pwdata[9:0];
					REG_PRESSURE_CEILING: ceiling_q     <= pwdata[9:0];
					REG_NOTE_NUMBER:      note_num_q    <= pwdata[6:0];
					REG_ACTIVE_KEYS:      active_keys_q <= pwdata[5:0];
					default: ;
				endcase
			end
			if (cal_begin) begin
				calibrating_q <= 1'b1;
				cal_vld_q     <= '0;
			end
			if (cal_end) calibrating_q <= 1'b0;
			if (last_we) last_vld_q[key_addr] <= 1'b1;
			if (cal_we) cal_vld_q[key_addr] <= 1'b1;
			if (state_q == ST_FINISH && evt_free) evt_valid_q <= 1'b1;
			else if (evt_ready) evt_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					sel_q   <= 1'b0;
					state_q <= to_prep ? ST_PREP : ST_FINISH;
				end
				ST_PREP: begin
					cnt_q <= '0;
					if (!p_zero) begin
						state_q <= ST_DIV;
					end else if (!sel_q) begin
						sel_q <= 1'b1;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_last) begin
						sel_q   <= 1'b1;
						state_q <= sel_q ? ST_DECIDE : ST_PREP;
					end
				end
				ST_DECIDE: state_q <= ST_FINISH;
				ST_FINISH: begin
					// hold until the output register is free
					if (evt_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req_acc) req_q <= req_data;
		if (state_q == ST_LOAD) begin
			last_q   <= last_val;
			kind_q   <= load_kind;
			amount_q <= load_amount;
			cmin_q   <= load_cmin;
			cmax_q   <= load_cmax;
		end
		if (state_q == ST_PREP) begin
			num_q <= p_num;
			den_q <= {p_range, 1'b0};
			rem_q <= '0;
			if (p_zero) begin
				if (sel_q) p_l_q <= 7'd0;
				else p_r_q <= 7'd0;
			end
		end
		if (state_q == ST_DIV) begin
			num_q <= num_next;
			rem_q <= rem_next;
			if (div_last) begin
				if (sel_q) p_l_q <= q_clamp;
				else p_r_q <= q_clamp;
			end
		end
		if (state_q == ST_DECIDE) begin
			kind_q   <= dec_kind;
			amount_q <= dec_amount;
		end
		if (state_q == ST_FINISH && evt_free) begin
			evt_q.event_kind <= kind_q;
			evt_q.key_out    <= (kind_q == EV_NONE) ? 5'd0 : req_q.key_index;
			evt_q.note       <= (kind_q == EV_NONE || kind_q == EV_CAL_UPDATE) ?
				7'd0 : note_num_q;
			evt_q.amount     <= amount_q;
			evt_q.cal_min    <= cmin_q;
			evt_q.cal_max    <= cmax_q;
		end
	end

	`KSNE_ASSERT_IMP(a_div_count_bound, clk, arst_n, state_q == ST_DIV, cnt_q <= CNT_W'(DIV_STEPS - 1))
	`KSNE_ASSERT_IMP(a_none_is_blank, clk, arst_n, evt_valid && evt_data.event_kind == EV_NONE, evt_data.key_out == 5'd0 && evt_data.note == 7'd0 && evt_data.amount == 7'd0 && evt_data.cal_min == 10'd0 && evt_data.cal_max == 10'd0)
	`KSNE_ASSERT_IMP(a_cal_range_order, clk, arst_n, evt_valid && evt_data.event_kind == EV_CAL_UPDATE, evt_data.cal_min <= evt_data.cal_max)
	`KSNE_ASSERT_IMP(a_note_off_silent, clk, arst_n, evt_valid && evt_data.event_kind == EV_NOTE_OFF, evt_data.amount == 7'd0)
	`KSNE_ASSERT_NXT(a_begin_sets_cal, clk, arst_n, state_q == ST_LOAD && req_q.req_type == REQ_CAL_BEGIN, calibrating_q)

endmodule
`default_nettype wire

FILE: verif/key_sensor_to_note_events_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the key sensor to note event unit: APB setup, random traffic, scoreboard.
module key_sensor_to_note_events_unit_tb;
	import ksne_pkg::*;

	localparam int KEYS = 32;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 75;
	localparam int PHASES = 9;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	key_req_t req_data = '0;
	logic evt_valid;
	logic evt_ready = 1'b0;
	note_evt_t evt_data;

	// register copies as the block should hold them
	logic set_mode = RST_PLAY_MODE;
	logic [9:0] set_threshold = RST_THRESHOLD;
	logic [9:0] set_floor = RST_FLOOR;
	logic [9:0] set_ceiling = RST_CEILING;
	logic [6:0] set_note = RST_NOTE_NUMBER;
	logic [5:0] set_active = RST_ACTIVE_KEYS;

	// per-key tables as the block should hold them
	logic [9:0] last_level [KEYS];
	logic [9:0] cal_low [KEYS];
	logic [9:0] cal_high [KEYS];
	bit calibrating_now = 1'b0;

	key_req_t pending_key_reqs[$];
	note_evt_t expected_note_events[$];
	int reqs_queued = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_active = 1'b0;
	int held_cycles = 0;

	key_sensor_to_note_events_unit #(
		.KEY_COUNT(KEYS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt_data(evt_data)
	);

	always #10 clk = ~clk;

	function automatic int unsigned pressure_level(logic [9:0] level);
		int unsigned span, scaled, p;
		if (set_ceiling <= set_floor || level >= set_ceiling)
			return 0;
		scaled = 127 * (set_ceiling - level);
		span = set_ceiling - set_floor;
		// round half up
		p = (2 * scaled + span) / (2 * span);
		return (p > 127) ? 127 : p;
	endfunction

	function automatic note_evt_t predict_note_event(key_req_t rq);
		note_evt_t ev;
		logic [9:0] prev;
		int unsigned vel, p_now, p_prev;
		ev = '0;
		if (rq.req_type == REQ_CAL_BEGIN) begin
			if (!calibrating_now) begin
				for (int k = 0; k < KEYS; k++) begin
					cal_low[k] = READING_MAX;
					cal_high[k] = '0;
				end
				calibrating_now = 1'b1;
			end
			return ev;
		end
		if (rq.req_type == REQ_CAL_END) begin
			calibrating_now = 1'b0;
			return ev;
		end
		if (rq.req_type != REQ_READING)
			return ev;
		if (calibrating_now) begin
			if (rq.reading < cal_low[rq.key_index])
				cal_low[rq.key_index] = rq.reading;
			if (rq.reading > cal_high[rq.key_index])
				cal_high[rq.key_index] = rq.reading;
			ev.event_kind = EV_CAL_UPDATE;
			ev.key_out = rq.key_index;
			ev.cal_min = cal_low[rq.key_index];
			ev.cal_max = cal_high[rq.key_index];
			return ev;
		end
		prev = last_level[rq.key_index];
		last_level[rq.key_index] = rq.reading;
		if (rq.key_index >= set_active)
			return ev;
		if (set_mode == 1'b0) begin
			if (rq.reading <= set_threshold && set_threshold < prev) begin
				vel = 2 * (prev - rq.reading);
				ev.event_kind = EV_NOTE_ON;
				ev.amount = (vel > 127) ? MIDI_MAX : 7'(vel);
			end else if (prev <= set_threshold && set_threshold < rq.reading) begin
				ev.event_kind = EV_NOTE_OFF;
			end
		end else begin
			p_now = pressure_level(rq.reading);
			p_prev = pressure_level(prev);
			if (p_now > 0) begin
				ev.event_kind = (p_prev == 0) ? EV_NOTE_ON : EV_POLY_PRESSURE;
				ev.amount = 7'(p_now);
			end else if (p_prev > 0) begin
				ev.event_kind = EV_NOTE_OFF;
			end
		end
		if (ev.event_kind == EV_NONE)
			return '0;
		ev.key_out = rq.key_index;
		ev.note = set_note;
		return ev;
	endfunction

	function automatic string describe_event(note_evt_t e);
		return $sformatf("kind %0d key %0d note %0d amount %0d min %0d max %0d",
			e.event_kind, e.key_out, e.note, e.amount, e.cal_min, e.cal_max);
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	// sender: hold valid and payload until the transaction is taken
	always @(posedge clk) begin : req_driver
		if (req_valid && req_ready)
			expected_note_events.insert(expected_note_events.size(),
				predict_note_event(req_data));
		if (!req_valid || req_ready) begin
			if (pending_key_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req_data <= pending_key_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : evt_receiver
		if (hold_active && held_cycles < HOLD_CYCLES) begin
			held_cycles <= held_cycles + 1;
			evt_ready <= 1'b0;
		end else begin
			evt_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : evt_monitor
		note_evt_t want;
		string bad;
		if (evt_valid && evt_ready) begin
			if (expected_note_events.size() == 0) begin
				report_mismatch({"unexpected result: ", describe_event(evt_data)});
			end else begin
				want = expected_note_events.pop_front();
				bad = "";
				if (evt_data.event_kind !== want.event_kind) bad = {bad, " event_kind"};
				if (evt_data.key_out !== want.key_out) bad = {bad, " key_out"};
				if (evt_data.note !== want.note) bad = {bad, " note"};
				if (evt_data.amount !== want.amount) bad = {bad, " amount"};
				if (evt_data.cal_min !== want.cal_min) bad = {bad, " cal_min"};
				if (evt_data.cal_max !== want.cal_max) bad = {bad, " cal_max"};
				if (bad != "")
					report_mismatch($sformatf("result %0d, wrong%s: got %s, want %s",
						results_checked, bad, describe_event(evt_data), describe_event(want)));
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL key_sensor_to_note_events_unit");
			$finish;
		end
	end

	task automatic write_setting(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PLAY_MODE: set_mode = value[0];
			REG_NOTE_THRESHOLD: set_threshold = value[9:0];
			REG_PRESSURE_FLOOR: set_floor = value[9:0];
			REG_PRESSURE_CEILING: set_ceiling = value[9:0];
			REG_NOTE_NUMBER: set_note = value[6:0];
			REG_ACTIVE_KEYS: set_active = value[5:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic mode, logic [9:0] thr, logic [9:0] flr,
		logic [9:0] ceil, logic [6:0] nt, logic [5:0] act);
		write_setting(REG_PLAY_MODE, 32'(mode));
		write_setting(REG_NOTE_THRESHOLD, 32'(thr));
		write_setting(REG_PRESSURE_FLOOR, 32'(flr));
		write_setting(REG_PRESSURE_CEILING, 32'(ceil));
		write_setting(REG_NOTE_NUMBER, 32'(nt));
		write_setting(REG_ACTIVE_KEYS, 32'(act));
	endtask

	task automatic queue_key_req(logic [1:0] kind, logic [4:0] key, logic [9:0] level);
		key_req_t rq;
		rq.req_type = kind;
		rq.key_index = key;
		rq.reading = level;
		pending_key_reqs.insert(pending_key_reqs.size(), rq);
		reqs_queued++;
	endtask

	// every queued item gives exactly one result
	task automatic wait_drained();
		do
			@(posedge clk);
		while (results_checked != reqs_queued);
	endtask

	function automatic logic [9:0] reading_near(int centre);
		int v;
		v = centre + int'($urandom_range(0, 160)) - 80;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return 10'(v);
	endfunction

	task automatic queue_random_reading();
		logic [4:0] key;
		int centre;
		int lim;
		lim = (set_active < 8) ? int'(set_active) : 8;
		if (lim != 0 && $urandom_range(0, 9) < 7)
			key = 5'($urandom_range(0, lim - 1));
		else
			key = 5'($urandom);
		if (set_mode == 1'b0)
			centre = set_threshold;
		else if (set_floor < set_ceiling)
			centre = $urandom_range(set_floor, set_ceiling);
		else
			centre = $urandom_range(0, 1023);
		if ($urandom_range(0, 1))
			queue_key_req(REQ_READING, key, reading_near(centre));
		else
			queue_key_req(REQ_READING, key, 10'($urandom));
	endtask

	initial begin : stimulus
		int ph;
		int i;
		int pick;
		int burst;
		logic [9:0] lo_level;
		for (int k = 0; k < KEYS; k++) begin
			last_level[k] = '0;
			cal_low[k] = READING_MAX;
			cal_high[k] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// velocity mode at reset settings: crossings, clamps, inactive keys, calibration
		queue_key_req(REQ_READING, 5'd0, 10'd500);
		queue_key_req(REQ_READING, 5'd0, 10'd100);
		queue_key_req(REQ_READING, 5'd0, 10'd350);
		queue_key_req(REQ_READING, 5'd0, 10'd351);
		queue_key_req(REQ_READING, 5'd0, 10'd340);
		queue_key_req(REQ_READING, 5'd2, 10'd0);
		queue_key_req(REQ_READING, 5'd2, 10'd1023);
		queue_key_req(REQ_READING, 5'd3, 10'd1023);
		queue_key_req(REQ_READING, 5'd31, 10'd1023);
		queue_key_req(2'd3, 5'd31, 10'd1023);
		queue_key_req(REQ_CAL_END, 5'd0, 10'd0);
		queue_key_req(REQ_CAL_BEGIN, 5'd0, 10'd0);
		queue_key_req(REQ_CAL_BEGIN, 5'd31, 10'd1023);
		queue_key_req(REQ_READING, 5'd0, 10'd512);
		queue_key_req(REQ_READING, 5'd0, 10'd0);
		queue_key_req(REQ_READING, 5'd31, 10'd1023);
		queue_key_req(REQ_CAL_END, 5'd0, 10'd0);
		queue_key_req(REQ_CAL_END, 5'd0, 10'd0);
		queue_key_req(REQ_READING, 5'd0, 10'd1023);
		wait_drained();

		// pressure mode: onset, poly pressure, rounding, clamp, release, resting at zero
		write_setting(REG_PLAY_MODE, 32'd1);
		queue_key_req(REQ_READING, 5'd0, 10'd480);
		queue_key_req(REQ_READING, 5'd0, 10'd300);
		queue_key_req(REQ_READING, 5'd0, 10'd390);
		queue_key_req(REQ_READING, 5'd0, 10'd479);
		queue_key_req(REQ_READING, 5'd0, 10'd0);
		queue_key_req(REQ_READING, 5'd0, 10'd1023);
		queue_key_req(REQ_READING, 5'd0, 10'd1023);
		wait_drained();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_settings(1'b0, 10'd0, 10'd300, 10'd480, 7'd0, 6'd32);
				1: apply_settings(1'b0, 10'd1023, 10'd0, 10'd1023, 7'd127, 6'd0);
				2: apply_settings(1'b0, 10'($urandom), 10'($urandom), 10'($urandom),
					7'($urandom), 6'($urandom_range(0, 32)));
				3: apply_settings(1'b1, 10'($urandom), 10'd0, 10'd1023, 7'($urandom), 6'd32);
				4: apply_settings(1'b1, 10'd350, 10'd1023, 10'd0, 7'($urandom), 6'd32);
				5: begin
					lo_level = 10'($urandom);
					apply_settings(1'b1, 10'($urandom), lo_level, lo_level, 7'($urandom),
						6'($urandom_range(1, 32)));
				end
				6: begin
					lo_level = 10'($urandom_range(0, 980));
					apply_settings(1'b1, 10'd350, lo_level,
						lo_level + 10'($urandom_range(1, 40)), 7'd60, 6'd32);
				end
				7: begin
					lo_level = 10'($urandom_range(0, 900));
					apply_settings(1'($urandom), 10'($urandom), lo_level,
						lo_level + 10'($urandom_range(1, 123)), 7'($urandom),
						6'($urandom_range(1, 32)));
				end
				default: apply_settings(1'b0, 10'($urandom_range(100, 900)), 10'($urandom),
					10'($urandom), 7'($urandom), 6'd32);
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 86; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 86; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			// long receiver hold-off while the sender keeps offering
			hold_active = (ph == 6);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					queue_key_req(REQ_CAL_BEGIN, 5'($urandom), 10'($urandom));
					for (burst = $urandom_range(3, 8); burst > 0; burst--)
						queue_key_req(REQ_READING, 5'($urandom), 10'($urandom));
					queue_key_req(REQ_CAL_END, 5'($urandom), 10'($urandom));
				end else if (pick < 6) begin
					queue_key_req(REQ_CAL_BEGIN, 5'($urandom), 10'($urandom));
				end else if (pick < 8) begin
					queue_key_req(REQ_CAL_END, 5'($urandom), 10'($urandom));
				end else if (pick < 9) begin
					queue_key_req(2'd3, 5'($urandom), 10'($urandom));
				end else begin
					queue_random_reading();
				end
			end
			wait_drained();
			hold_active = 1'b0;
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_note_events.size() == 0) begin
			$display("PASS key_sensor_to_note_events_unit");
		end else begin
			$display("FAIL key_sensor_to_note_events_unit");
		end
		$finish;
	end

endmodule
